// ===== rtl/scmc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the skin colour mask and centroid block.
// Used by scmc_mac, scmc_div and skin_color_mask_centroid_top; no dependencies.
package scmc_pkg;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Fixed field and state widths
  localparam int PIX_W     = 8;
  localparam int FW_W      = 13;
  localparam int CFG_IDX_W = 3;
  localparam int MATCH_W   = 25;
  localparam int SUM_W     = 36;
  localparam int CENT_W    = 12;
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);

  // Colour conversion datapath widths
  localparam int OPND_W = 9;
  localparam int COEF_W = 11;
  localparam int ACC_W  = 20;

  localparam logic signed [ACC_W-1:0]  RGB_ROUND  = 20'sd128;
  localparam logic signed [OPND_W-1:0] LUMA_OFS   = 9'sd16;
  localparam logic signed [OPND_W-1:0] CHROMA_OFS = 9'sd128;
  localparam logic [PIX_W-1:0]         MASK_ON    = 8'd255;
  localparam logic [PIX_W-1:0]         MASK_OFF   = 8'd0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_W   = 3'd4;

  // Configuration reset values
  localparam logic [PIX_W-1:0] REF_RED_RST   = 8'd143;
  localparam logic [PIX_W-1:0] REF_GREEN_RST = 8'd103;
  localparam logic [PIX_W-1:0] REF_BLUE_RST  = 8'd80;
  localparam logic [PIX_W-1:0] TOL_RST       = 8'd25;
  localparam logic [FW_W-1:0]  FRAME_W_RST   = 13'd3072;

  // Multiply-accumulate operations, one per conversion step
  typedef enum logic [2:0] {
    MAC_LUMA,
    MAC_RED_V,
    MAC_GRN_U,
    MAC_GRN_V,
    MAC_BLU_U
  } mac_op_e;

  typedef struct packed {
    logic    en;
    logic    add_base;
    mac_op_e op;
  } mac_ctrl_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LUMA,
    ST_RED,
    ST_GRN1,
    ST_GRN2,
    ST_BLU,
    ST_UPD,
    ST_DIVX,
    ST_DIVY,
    ST_DONE
  } state_e;

  function automatic logic signed [COEF_W-1:0] mac_coef(input mac_op_e op);
    logic signed [COEF_W-1:0] c;
    unique case (op)
      MAC_LUMA:  c = 11'sd298;
      MAC_RED_V: c = 11'sd409;
      MAC_GRN_U: c = -11'sd100;
      MAC_GRN_V: c = -11'sd208;
      MAC_BLU_U: c = 11'sd516;
      default:   c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/scmc_mac.sv =====
`timescale 1ns / 1ps
// Shared multiply-accumulate unit for the YUV to RGB conversion steps.
// Depends on scmc_pkg.
module scmc_mac (
  input  logic                                clk_i,
  input  scmc_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [scmc_pkg::OPND_W-1:0]  luma_c_i,
  input  logic signed [scmc_pkg::OPND_W-1:0]  chroma_d_i,
  input  logic signed [scmc_pkg::OPND_W-1:0]  chroma_e_i,
  output logic signed [scmc_pkg::ACC_W-1:0]   acc_o
);

  logic signed [scmc_pkg::OPND_W-1:0] opnd;
  logic signed [scmc_pkg::COEF_W-1:0] coef;
  logic signed [scmc_pkg::ACC_W-1:0]  prod;
  logic signed [scmc_pkg::ACC_W-1:0]  addend;
  logic signed [scmc_pkg::ACC_W-1:0]  acc_d, acc_q;
  logic signed [scmc_pkg::ACC_W-1:0]  base_d, base_q;

  always_comb begin
    unique case (ctrl_i.op)
      scmc_pkg::MAC_LUMA:  opnd = luma_c_i;
      scmc_pkg::MAC_RED_V: opnd = chroma_e_i;
      scmc_pkg::MAC_GRN_U: opnd = chroma_d_i;
      scmc_pkg::MAC_GRN_V: opnd = chroma_e_i;
      scmc_pkg::MAC_BLU_U: opnd = chroma_d_i;
      default:             opnd = '0;
    endcase
    coef   = scmc_pkg::mac_coef(ctrl_i.op);
    prod   = scmc_pkg::ACC_W'(coef) * scmc_pkg::ACC_W'(opnd);
    // start from the stored luma term plus rounding, or keep accumulating
    addend = ctrl_i.add_base ? (base_q + scmc_pkg::RGB_ROUND) : acc_q;
    acc_d  = acc_q;
    base_d = base_q;
    if (ctrl_i.en) begin
      if (ctrl_i.op == scmc_pkg::MAC_LUMA) begin
        base_d = prod;
      end else begin
        acc_d = addend + prod;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    base_q <= base_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/scmc_div.sv =====
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by both centroid axes.
// Depends on scmc_pkg.
module scmc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [scmc_pkg::SUM_W-1:0]   dividend_i,
  input  logic [scmc_pkg::MATCH_W-1:0] divisor_i,
  output logic                         done_o,
  output logic [scmc_pkg::SUM_W-1:0]   quotient_o
);

  logic                            busy_d, busy_q;
  logic [scmc_pkg::DIV_CNT_W-1:0]  cnt_d, cnt_q;
  logic [scmc_pkg::MATCH_W-1:0]    rem_d, rem_q;
  logic [scmc_pkg::MATCH_W-1:0]    dvs_d, dvs_q;
  logic [scmc_pkg::SUM_W-1:0]      quo_d, quo_q;
  logic [scmc_pkg::MATCH_W:0]      trial;
  logic [scmc_pkg::MATCH_W:0]      trial_sub;
  logic                            fits;
  logic                            step;

  always_comb begin
    trial     = {rem_q, quo_q[scmc_pkg::SUM_W-1]};
    trial_sub = trial - {1'b0, dvs_q};
    fits      = trial >= {1'b0, dvs_q};
    step      = busy_q && (cnt_q != '0);
    done_o    = busy_q && (cnt_q == '0);

    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = scmc_pkg::DIV_CNT_W'(scmc_pkg::SUM_W);
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (step) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? trial_sub[scmc_pkg::MATCH_W-1:0] : trial[scmc_pkg::MATCH_W-1:0];
      quo_d = {quo_q[scmc_pkg::SUM_W-2:0], fits};
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign quotient_o = quo_q;

endmodule

// ===== rtl/skin_color_mask_centroid_top.sv =====
`timescale 1ns / 1ps
// Skin colour mask with centroid: one pixel at a time, the next accepted only once the
// result is in the output register; the shared multiply-accumulate takes five steps per pixel.
// A frame's last pixel with matches adds two passes of the divider, one per centroid axis.
// Reset (async, active low) clears counters, sums and handshakes and loads the
// default reference colour, tolerance and frame width; no clearing pass is needed.
// Depends on scmc_pkg, scmc_mac and scmc_div.
module skin_color_mask_centroid_top #(
  parameter int MAX_WIDTH  = scmc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = scmc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [scmc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [scmc_pkg::FW_W-1:0]         cfg_data_i,
  // pixel input
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [23:0]                       s_axis_tdata_i,  // luma_value, chroma_u, chroma_v
  input  logic                              s_axis_tlast_i,  // end_of_frame
  // mask and centroid output
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [31:0]                       m_axis_tdata_o,  // mask_value, centroid_x, centroid_y
  output logic [1:0]                        m_axis_tuser_o   // centroid_valid, no_skin
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  // Configuration registers
  logic [scmc_pkg::PIX_W-1:0] ref_red_q, ref_green_q, ref_blue_q, tol_q;
  logic [scmc_pkg::FW_W-1:0]  frame_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_red_q   <= scmc_pkg::REF_RED_RST;
      ref_green_q <= scmc_pkg::REF_GREEN_RST;
      ref_blue_q  <= scmc_pkg::REF_BLUE_RST;
      tol_q       <= scmc_pkg::TOL_RST;
      frame_w_q   <= scmc_pkg::FRAME_W_RST;
    end else if (cfg_we_i) begin
      // unknown indexes fall through and are dropped
      if (cfg_idx_i == scmc_pkg::CFG_REF_RED)   ref_red_q   <= cfg_data_i[7:0];
      if (cfg_idx_i == scmc_pkg::CFG_REF_GREEN) ref_green_q <= cfg_data_i[7:0];
      if (cfg_idx_i == scmc_pkg::CFG_REF_BLUE)  ref_blue_q  <= cfg_data_i[7:0];
      if (cfg_idx_i == scmc_pkg::CFG_TOLERANCE) tol_q       <= cfg_data_i[7:0];
      if (cfg_idx_i == scmc_pkg::CFG_FRAME_W)   frame_w_q   <= cfg_data_i;
    end
  end

  // Sequencer and frame state
  scmc_pkg::state_e state_d, state_q;

  logic [scmc_pkg::PIX_W-1:0]   y_d, y_q, u_d, u_q, v_d, v_q;
  logic                         last_d, last_q;
  logic                         ok_d, ok_q;

  logic [CW-1:0]                col_d, col_q;
  logic [RW-1:0]                row_d, row_q;
  logic [scmc_pkg::MATCH_W-1:0] match_d, match_q;
  logic [scmc_pkg::SUM_W-1:0]   csum_d, csum_q, rsum_d, rsum_q;

  // Per-pixel result, held until the output register is free
  logic                         hit_d, hit_q;
  logic                         cval_d, cval_q;
  logic                         none_d, none_q;
  logic [scmc_pkg::CENT_W-1:0]  cx_d, cx_q, cy_d, cy_q;

  // Output register
  logic                         m_valid_d, m_valid_q;
  logic [31:0]                  m_data_d, m_data_q;
  logic [1:0]                   m_user_d, m_user_q;

  // Shared units
  scmc_pkg::mac_ctrl_t                 mac_ctrl;
  logic signed [scmc_pkg::OPND_W-1:0]  luma_c, chroma_d, chroma_e;
  logic signed [scmc_pkg::ACC_W-1:0]   mac_acc;

  logic                         div_start, div_done;
  logic [scmc_pkg::SUM_W-1:0]   div_dividend, div_quot;
  logic [scmc_pkg::MATCH_W-1:0] div_divisor;

  // Comparator: clamp the finished channel and test it against its reference
  logic [scmc_pkg::PIX_W-1:0]   chan, chan_ref, chan_diff;
  logic                         in_tol;

  // Update helpers
  logic [CW:0]                  width_eff;
  logic                         take;
  logic [scmc_pkg::MATCH_W-1:0] match_upd;
  logic [scmc_pkg::SUM_W-1:0]   csum_upd, rsum_upd;
  logic                         accept_in;

  assign luma_c   = $signed({1'b0, y_q}) - scmc_pkg::LUMA_OFS;
  assign chroma_d = $signed({1'b0, u_q}) - scmc_pkg::CHROMA_OFS;
  assign chroma_e = $signed({1'b0, v_q}) - scmc_pkg::CHROMA_OFS;

  scmc_mac u_mac (
    .clk_i      (clk_i),
    .ctrl_i     (mac_ctrl),
    .luma_c_i   (luma_c),
    .chroma_d_i (chroma_d),
    .chroma_e_i (chroma_e),
    .acc_o      (mac_acc)
  );

  scmc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    // negative sums clamp to zero, anything past 255 after the shift clamps to 255
    if (mac_acc[scmc_pkg::ACC_W-1]) begin
      chan = '0;
    end else if (|mac_acc[scmc_pkg::ACC_W-2:16]) begin
      chan = 8'd255;
    end else begin
      chan = mac_acc[15:8];
    end
    unique case (state_q)
      scmc_pkg::ST_GRN1: chan_ref = ref_red_q;
      scmc_pkg::ST_BLU:  chan_ref = ref_green_q;
      default:           chan_ref = ref_blue_q;
    endcase
    chan_diff = (chan > chan_ref) ? (chan - chan_ref) : (chan_ref - chan);
    in_tol    = chan_diff <= tol_q;
  end

  always_comb begin
    // frame width of zero acts as one, anything past the maximum as the maximum
    if (frame_w_q == '0) begin
      width_eff = (CW+1)'(1);
    end else if (32'(frame_w_q) > MAX_WIDTH) begin
      width_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      width_eff = (CW+1)'(frame_w_q);
    end
    // a saturated match counter stops counting and summing
    take      = ok_q && in_tol && !(&match_q);
    match_upd = take ? match_q + 1'b1 : match_q;
    csum_upd  = take ? csum_q + scmc_pkg::SUM_W'(col_q) : csum_q;
    rsum_upd  = take ? rsum_q + scmc_pkg::SUM_W'(row_q) : rsum_q;
  end

  always_comb begin
    state_d   = state_q;
    y_d       = y_q;
    u_d       = u_q;
    v_d       = v_q;
    last_d    = last_q;
    ok_d      = ok_q;
    col_d     = col_q;
    row_d     = row_q;
    match_d   = match_q;
    csum_d    = csum_q;
    rsum_d    = rsum_q;
    hit_d     = hit_q;
    cval_d    = cval_q;
    none_d    = none_q;
    cx_d      = cx_q;
    cy_d      = cy_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    // free the output register once its transaction completes
    m_valid_d = m_valid_q && !m_axis_tready_i;

    mac_ctrl     = '{en: 1'b0, add_base: 1'b0, op: scmc_pkg::MAC_LUMA};
    div_start    = 1'b0;
    div_dividend = rsum_q;
    div_divisor  = match_q;
    accept_in    = 1'b0;

    unique case (state_q)
      scmc_pkg::ST_IDLE: begin
        accept_in = s_axis_tvalid_i;
        if (s_axis_tvalid_i) begin
          y_d     = s_axis_tdata_i[7:0];
          u_d     = s_axis_tdata_i[15:8];
          v_d     = s_axis_tdata_i[23:16];
          last_d  = s_axis_tlast_i;
          state_d = scmc_pkg::ST_LUMA;
        end
      end
      scmc_pkg::ST_LUMA: begin
        mac_ctrl = '{en: 1'b1, add_base: 1'b0, op: scmc_pkg::MAC_LUMA};
        state_d  = scmc_pkg::ST_RED;
      end
      scmc_pkg::ST_RED: begin
        mac_ctrl = '{en: 1'b1, add_base: 1'b1, op: scmc_pkg::MAC_RED_V};
        state_d  = scmc_pkg::ST_GRN1;
      end
      scmc_pkg::ST_GRN1: begin
        ok_d     = in_tol;
        mac_ctrl = '{en: 1'b1, add_base: 1'b1, op: scmc_pkg::MAC_GRN_U};
        state_d  = scmc_pkg::ST_GRN2;
      end
      scmc_pkg::ST_GRN2: begin
        mac_ctrl = '{en: 1'b1, add_base: 1'b0, op: scmc_pkg::MAC_GRN_V};
        state_d  = scmc_pkg::ST_BLU;
      end
      scmc_pkg::ST_BLU: begin
        ok_d     = ok_q && in_tol;
        mac_ctrl = '{en: 1'b1, add_base: 1'b1, op: scmc_pkg::MAC_BLU_U};
        state_d  = scmc_pkg::ST_UPD;
      end
      scmc_pkg::ST_UPD: begin
        hit_d   = ok_q && in_tol;
        match_d = match_upd;
        csum_d  = csum_upd;
        rsum_d  = rsum_upd;
        cval_d  = 1'b0;
        none_d  = 1'b0;
        cx_d    = '0;
        cy_d    = '0;
        if (last_q) begin
          col_d = '0;
          row_d = '0;
          if (match_upd == '0) begin
            none_d  = 1'b1;
            state_d = scmc_pkg::ST_DONE;
          end else begin
            // hold the sums for the divider; clear them once both axes are done
            div_start    = 1'b1;
            div_dividend = csum_upd;
            div_divisor  = match_upd;
            state_d      = scmc_pkg::ST_DIVX;
          end
        end else begin
          if (({1'b0, col_q} + (CW+1)'(1)) >= width_eff) begin
            col_d = '0;
            if (32'(row_q) < MAX_HEIGHT - 1) begin
              row_d = row_q + 1'b1;
            end
          end else begin
            col_d = col_q + 1'b1;
          end
          state_d = scmc_pkg::ST_DONE;
        end
      end
      scmc_pkg::ST_DIVX: begin
        if (div_done) begin
          cx_d      = div_quot[scmc_pkg::CENT_W-1:0];
          div_start = 1'b1;
          state_d   = scmc_pkg::ST_DIVY;
        end
      end
      scmc_pkg::ST_DIVY: begin
        if (div_done) begin
          cy_d    = div_quot[scmc_pkg::CENT_W-1:0];
          cval_d  = 1'b1;
          match_d = '0;
          csum_d  = '0;
          rsum_d  = '0;
          state_d = scmc_pkg::ST_DONE;
        end
      end
      scmc_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {cy_q, cx_q, hit_q ? scmc_pkg::MASK_ON : scmc_pkg::MASK_OFF};
          m_user_d  = {none_q, cval_q};
          if (last_q && !cval_q) begin
            // empty frame: nothing went to the divider, so clear the sums here
            match_d = '0;
            csum_d  = '0;
            rsum_d  = '0;
          end
          state_d = scmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = scmc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= scmc_pkg::ST_IDLE;
      col_q     <= '0;
      row_q     <= '0;
      match_q   <= '0;
      csum_q    <= '0;
      rsum_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      match_q   <= match_d;
      csum_q    <= csum_d;
      rsum_q    <= rsum_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q      <= y_d;
    u_q      <= u_d;
    v_q      <= v_d;
    last_q   <= last_d;
    ok_q     <= ok_d;
    hit_q    <= hit_d;
    cval_q   <= cval_d;
    none_q   <= none_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign s_axis_tready_o = (state_q == scmc_pkg::ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef SYNTHESIS
  // one pixel in flight: no second transaction right after an accepted one
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_in |=> !s_axis_tready_o)
    else $error("input accepted while a pixel is in flight");

  // a result never claims both a centroid and an empty frame
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("centroid_valid and no_skin both set");

  // results without a centroid carry zero coordinates
  a_zero_cent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tdata_o[31:8] == '0))
    else $error("centroid coordinates set without centroid_valid");

  // the divider only finishes while the sequencer waits on it
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == scmc_pkg::ST_DIVX || state_q == scmc_pkg::ST_DIVY))
    else $error("divider finished outside a division state");
`endif

endmodule
